[rtl/core/brun_pkg.sv]
// Package for the bitmap run engine: sizes, command codes, control structs.
// Used by brun_ctrl, brun_dp and the top level; no dependencies.
package brun_pkg;

   localparam int unsigned BITMAP_BITS_DEF = 65536;
   localparam int unsigned MAX_RUN_DEF     = 1024;

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_INVERT = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // compute bounds, set walk start
      logic rd;        // issue read of current byte
      logic wr;        // write modified byte, advance
      logic scan;      // evaluate byte for find, advance
      logic fin;       // register result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_find;
      logic skip;      // no walk needed (zero length, bounds error, empty find)
      logic last;      // current byte is the last to walk
      logic stop;      // find walk is done after this byte
   } sts_type;

   // ones from LSB in a byte
   function automatic logic [3:0] ones_lsb(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd8;
      for (int k = 7; k >= 0; k--) if (!b[k]) n = 4'(k);
      return n;
   endfunction

   // index of lowest set bit, 8 when none
   function automatic logic [3:0] low_set(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd8;
      for (int k = 7; k >= 0; k--) if (b[k]) n = 4'(k);
      return n;
   endfunction

endpackage

[rtl/core/brun_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module brun_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // read one word per cycle, and write it as well when we is set
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

[rtl/core/brun_ctrl.sv]
// Controller state machine for the bitmap run engine.
// Depends on brun_pkg.
module brun_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             clr_done,
   output logic             busy,
   input  brun_pkg::sts_type sts,
   output brun_pkg::ctl_type ctl
);
   import brun_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_RD   = 6'b000100,
      ST_WAIT = 6'b001000,
      ST_EXEC = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && clr_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            if (sts.skip) state_in = ST_FIN;
            else begin
               ctl.rd   = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_EXEC;
         ST_EXEC: begin
            if (sts.is_find) begin
               ctl.scan = 1'b1;
               state_in = (sts.stop || sts.last) ? ST_FIN : ST_RD;
            end else begin
               ctl.wr   = 1'b1;
               state_in = sts.last ? ST_FIN : ST_RD;
            end
         end
         ST_FIN: begin
            ctl.fin  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE) || !clr_done;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |=> state_ff == ST_IDLE) else $error("fin not followed by idle");
   a_wait_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |=> state_ff == ST_EXEC) else $error("read wait broken");
endmodule

[rtl/core/brun_dp.sv]
// Datapath for the bitmap run engine: request registers, byte walk, result.
// Depends on brun_pkg and brun_ram.
module brun_dp #(
   parameter int unsigned BITMAP_BITS = brun_pkg::BITMAP_BITS_DEF,
   parameter int unsigned MAX_RUN     = brun_pkg::MAX_RUN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start_acc,
   input  logic [1:0]        req_cmd,
   input  logic [15:0]       req_bit_offset,
   input  logic [16:0]       req_run_length,
   input  logic [16:0]       size_cfg,
   input  brun_pkg::ctl_type ctl,
   output brun_pkg::sts_type sts,
   output logic              clr_done,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [13:0]       rsp_bytes_changed,
   output logic [12:0]       rsp_first_byte_index,
   output logic [16:0]       rsp_found_offset,
   output logic [10:0]       rsp_found_length,
   output logic [16:0]       rsp_next_offset
);
   import brun_pkg::*;

   localparam int unsigned DEPTH = (BITMAP_BITS + 7) / 8;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SW    = $clog2(BITMAP_BITS + 1);
   // offset plus length needs 18 bits
   localparam int unsigned WW    = (SW > 18) ? SW : 18;
   localparam int unsigned LW    = $clog2(MAX_RUN + 1);

   // request, bounds and walk registers
   logic [1:0]    cmd_ff;
   logic [WW-1:0] off_ff, end_ff, size_ff;
   logic [WW-1:0] i_ff, i_in;           // byte index of walk
   logic [WW-1:0] lb_ff;                // last byte index
   logic          skip_ff, err_ff;
   logic          found_ff;
   logic [WW-1:0] p_ff;
   logic [LW-1:0] flen_ff;
   logic [AW:0]   clr_ff;

   logic [WW-1:0] size_c, off_c, len_c, end_c;

   // clip configured size, widen offset and length, form end bit
   always_comb begin
      size_c = (WW'(size_cfg) < WW'(BITMAP_BITS)) ? WW'(size_cfg) : WW'(BITMAP_BITS);
      off_c  = WW'(req_bit_offset);
      len_c  = WW'(req_run_length);
      end_c  = off_c + len_c;
   end

   // RAM port
   logic [7:0]    rdata, wdata, ram_wdata;
   logic          we;
   logic [AW-1:0] addr;

   brun_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(ram_wdata), .rdata(rdata)
   );

   assign clr_done = clr_ff[AW];

   // byte masks, scan values and write data for current index
   logic [7:0]    run_m, last_m, b_cur, b_scan;
   logic [WW-1:0] lastbits, hi_w;
   logic [3:0]    lo, hi, t, c, ls;
   logic          first_byte, is_last;
   always_comb begin
      first_byte = (i_ff == (off_ff >> 3));
      lo   = first_byte ? {1'b0, off_ff[2:0]} : 4'd0;
      hi_w = end_ff - (i_ff << 3);
      hi   = (hi_w > WW'(8)) ? 4'd8 : hi_w[3:0];
      run_m = (8'hFF << lo) & (8'hFF >> (4'd8 - hi));
      is_last  = (i_ff == lb_ff);
      lastbits = size_ff - (lb_ff << 3);
      last_m   = 8'hFF >> (4'd8 - lastbits[3:0]);
      b_cur    = (cmd_ff == CMD_FIND && is_last) ? (rdata & last_m) : rdata;
      b_scan   = first_byte ? (b_cur & (8'hFF << off_ff[2:0])) : b_cur;
      ls = low_set(b_scan);
      t  = ones_lsb(b_cur >> ls[2:0]);
      c  = ones_lsb(b_cur);
      case (cmd_ff)
         CMD_SET:   wdata = rdata | run_m;
         CMD_CLEAR: wdata = rdata & ~run_m;
         default:   wdata = rdata ^ run_m;
      endcase
   end

   // write zeros while the clearing pass runs
   assign ram_wdata = clr_done ? wdata : 8'd0;
   assign we   = !clr_done || ctl.wr;
   assign addr = !clr_done ? clr_ff[AW-1:0] : i_ff[AW-1:0];

   assign sts.is_find = (cmd_ff == CMD_FIND);
   assign sts.skip    = skip_ff;
   assign sts.last    = is_last;
   logic [LW:0] sum;
   always_comb begin
      sum = (LW+1)'(flen_ff) + (LW+1)'(c);
      sts.stop = found_ff ? ((sum > (LW+1)'(MAX_RUN)) || c < 4'd8)
                          : ((b_scan != 8'd0) && (ls + t < 4'd8));
   end

   // walk index
   always_comb begin
      i_in = i_ff;
      if (ctl.load) i_in = off_ff >> 3;
      else if (ctl.wr || ctl.scan) i_in = i_ff + WW'(1);
   end

   // clear sweep after reset
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (!clr_done) clr_ff <= clr_ff + (AW+1)'(1);
   end

   // request capture and walk
   always_ff @(posedge clock) begin
      i_ff <= i_in;
      if (start_acc) begin
         cmd_ff  <= req_cmd;
         off_ff  <= off_c;
         end_ff  <= end_c;
         size_ff <= size_c;
      end
      if (ctl.load) begin
         found_ff <= 1'b0;
         flen_ff  <= '0;
         p_ff     <= size_ff;
         if (cmd_ff == CMD_FIND) begin
            err_ff  <= 1'b0;
            skip_ff <= !(off_ff < size_ff);
            lb_ff   <= ((size_ff + WW'(7)) >> 3) - WW'(1);
         end else begin
            err_ff  <= (off_ff >= size_ff || end_ff > size_ff) && end_ff != off_ff;
            skip_ff <= (end_ff == off_ff) || off_ff >= size_ff || end_ff > size_ff;
            lb_ff   <= (end_ff - WW'(1)) >> 3;
         end
      end
      if (ctl.scan) begin
         if (!found_ff) begin
            if (b_scan != 8'd0) begin
               found_ff <= 1'b1;
               p_ff     <= (i_ff << 3) + WW'(ls);
               flen_ff  <= LW'(t);
            end
         end else if (!(sum > (LW+1)'(MAX_RUN))) begin
            flen_ff <= sum[LW-1:0];
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= ctl.fin;
      if (ctl.fin) begin
         rsp_status           <= err_ff;
         rsp_bytes_changed    <= '0;
         rsp_first_byte_index <= '0;
         rsp_found_offset     <= '0;
         rsp_found_length     <= '0;
         rsp_next_offset      <= '0;
         if (cmd_ff == CMD_FIND) begin
            rsp_found_offset <= 17'(p_ff);
            rsp_found_length <= 11'(flen_ff);
            rsp_next_offset  <= 17'(p_ff + WW'(flen_ff));
         end else if (!skip_ff) begin
            rsp_bytes_changed    <= 14'(lb_ff - (off_ff >> 3) + WW'(1));
            rsp_first_byte_index <= 13'(off_ff >> 3);
         end
      end
   end

   a_wr_clr: assert property (@(posedge clock) disable iff (reset)
      ctl.wr |-> clr_done) else $error("write during clear");
   a_len: assert property (@(posedge clock) disable iff (reset)
      ctl.fin |-> flen_ff <= LW'(MAX_RUN)) else $error("run too long");
   a_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");
endmodule

[rtl/core/bitmap_run_engine_core.sv]
// Bitmap run engine top level: set/clear/invert/find runs over a byte bitmap.
// A command passes through load, then read, wait and exec per byte walked, then fin; one command
// at a time (busy). The RAM port (read per byte walked, written back but on find) sets throughput.
// After reset a clearing pass writes zeros to every RAM byte with busy high.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
module bitmap_run_engine_core #(
   parameter int unsigned BITMAP_BITS = brun_pkg::BITMAP_BITS_DEF,
   parameter int unsigned MAX_RUN     = brun_pkg::MAX_RUN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_bit_offset,
   input  logic [16:0] req_run_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_bitmap_bits,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [13:0] rsp_bytes_changed,
   output logic [12:0] rsp_first_byte_index,
   output logic [16:0] rsp_found_offset,
   output logic [10:0] rsp_found_length,
   output logic [16:0] rsp_next_offset
);
   import brun_pkg::*;

   ctl_type     ctl;
   sts_type     sts;
   logic        clr_done;
   logic [16:0] size_ff;

   // size register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) size_ff <= 17'h10000;
      else if (csr_valid) size_ff <= csr_bitmap_bits;
   end

   brun_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .clr_done(clr_done),
      .busy(busy), .sts(sts), .ctl(ctl)
   );

   brun_dp #(.BITMAP_BITS(BITMAP_BITS), .MAX_RUN(MAX_RUN)) u_dp (
      .clock(clock), .reset(reset), .start_acc(start && !busy),
      .req_cmd(req_cmd), .req_bit_offset(req_bit_offset),
      .req_run_length(req_run_length), .size_cfg(size_ff), .ctl(ctl), .sts(sts),
      .clr_done(clr_done), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_bytes_changed(rsp_bytes_changed), .rsp_first_byte_index(rsp_first_byte_index),
      .rsp_found_offset(rsp_found_offset), .rsp_found_length(rsp_found_length),
      .rsp_next_offset(rsp_next_offset)
   );
endmodule
